/* src/ps2t_pkg.sv */
// Package: shared constants, packet struct and clamp function for the PS/2 cursor tracker.
package ps2t_pkg;

   // Coordinate width of the cursor position
   localparam int COORD_BITS = 10;
   localparam int COORD_W    = COORD_BITS + 2;   // signed working width for add and clamp
   localparam int COORD_SPAN = 1 << COORD_BITS;
   localparam logic [COORD_BITS-1:0] COORD_MASK = {COORD_BITS{1'b1}};

   // Register and field widths
   localparam int SIZE_W  = 11;
   localparam int BYTE_W  = 8;
   localparam int BTN_W   = 3;
   localparam int CSR_IDX_W = 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   // Header bit positions
   localparam int HDR_SYNC_BIT  = 3;
   localparam int HDR_XSIGN_BIT = 4;
   localparam int HDR_YSIGN_BIT = 5;

   // Reset values
   localparam logic [SIZE_W-1:0]     RESET_W = SIZE_W'(800);
   localparam logic [SIZE_W-1:0]     RESET_H = SIZE_W'(600);
   localparam logic [COORD_BITS-1:0] RESET_X = COORD_BITS'(400);
   localparam logic [COORD_BITS-1:0] RESET_Y = COORD_BITS'(300);

   // One framed packet, presented when its third byte steps through
   typedef struct packed {
      logic              done;
      logic [BTN_W-1:0]  buttons;
      logic              x_sign;
      logic              y_sign;
      logic [BYTE_W-1:0] x_byte;
      logic [BYTE_W-1:0] y_byte;
   } ps2t_pkt_type;

   // Clamp a signed coordinate to 0 .. size-1; size 0 acts as 1
   function automatic logic [COORD_BITS-1:0] clamp_coord(
      input logic signed [COORD_W-1:0] v,
      input logic [SIZE_W-1:0]         size
   );
      logic [COORD_W-1:0]    size_ext;
      logic [COORD_BITS-1:0] hi;
      logic [COORD_BITS-1:0] res;
      size_ext = COORD_W'(size);
      if (size == '0) begin
         hi = '0;
      end else if (size_ext > COORD_W'(COORD_SPAN)) begin
         hi = COORD_MASK;
      end else begin
         hi = COORD_BITS'(size_ext - COORD_W'(1));
      end
      if (v < 0) begin
         res = '0;
      end else if (v > $signed({2'b00, hi})) begin
         res = hi;
      end else begin
         res = COORD_BITS'(v);
      end
      return res;
   endfunction

endpackage

/* src/ps2t_if.sv */
// Interfaces: received-byte channel and cursor result channel.
interface ps2t_req_if;
   import ps2t_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2t_rsp_if;
   import ps2t_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] cursor_x;
   logic [COORD_BITS-1:0] cursor_y;
   logic [BTN_W-1:0]      buttons;
   modport source (output valid, output cursor_x, output cursor_y, output buttons, input ready);
   modport sink   (input valid, input cursor_x, input cursor_y, input buttons, output ready);
endinterface

/* src/ps2_mouse_packet_cursor_tracker.sv */
// Top level: PS/2 mouse three-byte packet framer with clamped cursor tracking.
// Takes one received mouse byte per beat, every cycle if the result side keeps up.
// Each byte lands in an input register; from there framing, delta sign extension,
// the position add and the clamp to the screen size run combinationally into the
// result register, so a packet's result reaches the output through the input
// register and then the result register. The position feedback loop (add plus
// clamp) is a combinational path between the position registers, which sets the
// rate of one byte per cycle while the result side keeps up. Header bytes without
// the sync bit are dropped. A result waiting in the output register does not stop
// header or X bytes; only a third byte waits for it to drain.
// screen_width (index 0) and screen_height (index 1) reset to 800 and 600.
module ps2_mouse_packet_cursor_tracker (
   input  logic                           clock,
   input  logic                           reset,
   ps2t_req_if.sink                       req_bus,
   ps2t_rsp_if.source                     rsp_bus,
   input  logic                           csr_we,
   input  logic [ps2t_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ps2t_pkg::SIZE_W-1:0]    csr_wdata
);
   import ps2t_pkg::*;

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   ps2t_pkt_type      pkt;
   logic              out_free;
   logic              step;
   logic              fire;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_W;
         height_ff <= RESET_H;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Held byte moves on unless it completes a packet and the result is blocked
   assign step = in_valid_ff && (!pkt.done || out_free);
   assign fire = step && pkt.done;
   assign req_bus.ready = !in_valid_ff || step;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.rx_byte;
      end
   end

   ps2t_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (in_valid_ff),
      .byte_data  (in_byte_ff),
      .step       (step),
      .pkt        (pkt)
   );

   ps2t_cursor u_cursor (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .pkt           (pkt),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .out_free      (out_free),
      .rsp           (rsp_bus)
   );

endmodule

/* src/ps2t_framer.sv */
// Packet framer: tracks byte phase and holds header and X delta bytes.
module ps2t_framer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           byte_valid,
   input  logic [ps2t_pkg::BYTE_W-1:0]    byte_data,
   input  logic                           step,
   output ps2t_pkg::ps2t_pkt_type         pkt
);
   import ps2t_pkg::*;

   localparam logic [1:0] PH_HDR = 2'd0;
   localparam logic [1:0] PH_X   = 2'd1;
   localparam logic [1:0] PH_Y   = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] header_ff, header_in;
   logic [BYTE_W-1:0] xbyte_ff, xbyte_in;

   // Next phase and byte capture
   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      xbyte_in  = xbyte_ff;
      unique case (phase_ff)
         PH_X: begin
            xbyte_in = byte_data;
            phase_in = PH_Y;
         end
         PH_Y: begin
            phase_in = PH_HDR;
         end
         default: begin
            // header phase (and the unused code): resync on missing sync bit
            if (byte_data[HDR_SYNC_BIT]) begin
               header_in = byte_data;
               phase_in  = PH_X;
            end else begin
               phase_in  = PH_HDR;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         header_ff <= header_in;
         xbyte_ff  <= xbyte_in;
      end
   end

   // Completed packet view for the cursor stage
   always_comb begin
      pkt.done    = byte_valid && (phase_ff == PH_Y);
      pkt.buttons = header_ff[BTN_W-1:0];
      pkt.x_sign  = header_ff[HDR_XSIGN_BIT];
      pkt.y_sign  = header_ff[HDR_YSIGN_BIT];
      pkt.x_byte  = xbyte_ff;
      pkt.y_byte  = byte_data;
   end

endmodule

/* src/ps2t_cursor.sv */
// Cursor stage: position registers, add and clamp, result register.
module ps2t_cursor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  ps2t_pkg::ps2t_pkt_type      pkt,
   input  logic [ps2t_pkg::SIZE_W-1:0] screen_width,
   input  logic [ps2t_pkg::SIZE_W-1:0] screen_height,
   output logic                        out_free,
   ps2t_rsp_if.source                  rsp
);
   import ps2t_pkg::*;

   logic [COORD_BITS-1:0]     pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]     pos_y_ff, pos_y_in;
   logic                      out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0]     out_x_ff, out_y_ff;
   logic [BTN_W-1:0]          out_btn_ff;
   logic signed [COORD_W-1:0] dx, dy, sum_x, sum_y;

   // 9-bit deltas from header sign bits, then add/subtract and clamp
   always_comb begin
      dx       = COORD_W'($signed({pkt.x_sign, pkt.x_byte}));
      dy       = COORD_W'($signed({pkt.y_sign, pkt.y_byte}));
      sum_x    = $signed({2'b00, pos_x_ff}) + dx;
      sum_y    = $signed({2'b00, pos_y_ff}) - dy;
      pos_x_in = clamp_coord(sum_x, screen_width);
      pos_y_in = clamp_coord(sum_y, screen_height);
   end

   assign out_free     = !out_valid_ff || rsp.ready;
   assign out_valid_in = fire || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= RESET_X;
         pos_y_ff     <= RESET_Y;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         out_x_ff   <= pos_x_in;
         out_y_ff   <= pos_y_in;
         out_btn_ff <= pkt.buttons;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.cursor_x = out_x_ff;
   assign rsp.cursor_y = out_y_ff;
   assign rsp.buttons  = out_btn_ff;

endmodule
